/* design/voxel_face_culling_mesher_macros.svh */
// assertion macros shared by the mesher modules
// expects clk and rst_n in the scope of each use
`ifndef VOXEL_FACE_CULLING_MESHER_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_MACROS_SVH

// same-cycle implication
`define VFCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vfcm_pkg.sv */
// shared types, codes and the triangle corner table of the voxel mesher
// no dependencies
package vfcm_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int COORD_W       = 4;
  localparam int VERT_W        = 13;
  localparam int FACE_W        = 3;
  localparam int TRI_W         = 16;
  localparam int NUM_FACES     = 6;
  localparam int Q_DEPTH       = 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_MESH  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd2;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd3;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd4;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic               solid;
  } in_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;
    logic [FACE_W-1:0] face;
    logic [TRI_W-1:0]  tri_number;
    logic              last;
  } out_item_t;

  // command from the front to the back
  typedef struct packed {
    logic                 is_start;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [COORD_W-1:0]   cell_z;
    logic [NUM_FACES-1:0] exposed;
  } cmd_t;

  // corner code is {dz, dy, dx}, offset from the cell's low corner
  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
  } tri_corners_t;

  function automatic tri_corners_t tri_corners(input logic [FACE_W-1:0] face,
                                               input logic half);
    tri_corners_t t;
    t = '0;
    case ({face, half})
      {FACE_BACK,   1'b0}: t = '{3'b011, 3'b001, 3'b000};
      {FACE_BACK,   1'b1}: t = '{3'b000, 3'b010, 3'b011};
      {FACE_FRONT,  1'b0}: t = '{3'b100, 3'b101, 3'b111};
      {FACE_FRONT,  1'b1}: t = '{3'b111, 3'b110, 3'b100};
      {FACE_BOTTOM, 1'b0}: t = '{3'b000, 3'b001, 3'b101};
      {FACE_BOTTOM, 1'b1}: t = '{3'b101, 3'b100, 3'b000};
      {FACE_TOP,    1'b0}: t = '{3'b111, 3'b011, 3'b010};
      {FACE_TOP,    1'b1}: t = '{3'b010, 3'b110, 3'b111};
      {FACE_LEFT,   1'b0}: t = '{3'b110, 3'b010, 3'b000};
      {FACE_LEFT,   1'b1}: t = '{3'b100, 3'b110, 3'b000};
      {FACE_RIGHT,  1'b0}: t = '{3'b111, 3'b011, 3'b001};
      {FACE_RIGHT,  1'b1}: t = '{3'b101, 3'b111, 3'b001};
      default:             t = '0;
    endcase
    return t;
  endfunction

endpackage

/* design/vfcm_front.sv */
// front end: takes items, owns the occupancy memory, probes the six neighbors
// depends on vfcm_pkg
module vfcm_front
  import vfcm_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_push,
  output cmd_t     q_data,
  input  logic     q_full
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam logic [5:0] GRID_C = 6'(GRID_SIZE);
  localparam logic [AW-1:0] ROW_STEP   = AW'(GRID_SIZE);
  localparam logic [AW-1:0] PLANE_STEP = AW'(GRID_SIZE * GRID_SIZE);

  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_BACK   = 3'd1;
  localparam logic [2:0] STEP_FRONT  = 3'd2;
  localparam logic [2:0] STEP_BOTTOM = 3'd3;
  localparam logic [2:0] STEP_TOP    = 3'd4;
  localparam logic [2:0] STEP_LEFT   = 3'd5;
  localparam logic [2:0] STEP_RIGHT  = 3'd6;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_READ = 4'b0010,
    F_FIN  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t         state_r, state_nxt;
  logic [COORD_W-1:0]   x_r, y_r, z_r;
  logic [2:0]           step_r, step_nxt;
  logic                 cap_en_r, cap_in_r;
  logic [2:0]           cap_step_r;
  logic                 rd_data_r;
  logic                 center_r, center_nxt;
  logic [NUM_FACES-1:0] exposed_r, exposed_nxt;
  logic                 occ_mem_r [CELLS];

  logic [5:0]    ex, ey, ez, nx, ny, nz;
  logic [5:0]    ix, iy, iz;
  logic          nb_in, in_inside, accept, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  assign ix = {2'b00, in_data.cell_x};
  assign iy = {2'b00, in_data.cell_y};
  assign iz = {2'b00, in_data.cell_z};
  assign in_inside = (ix < GRID_C) && (iy < GRID_C) && (iz < GRID_C);
  assign wr_en   = accept && (in_data.func == FUNC_WRITE) && in_inside;
  assign wr_addr = AW'(iz) * PLANE_STEP + AW'(iy) * ROW_STEP + AW'(ix);

  // neighbor coordinate for the current probe, below zero wraps high and reads outside
  always_comb begin
    ex = {2'b00, x_r};
    ey = {2'b00, y_r};
    ez = {2'b00, z_r};
    nx = ex;
    ny = ey;
    nz = ez;
    case (step_r)
      STEP_BACK:   nz = ez - 6'd1;
      STEP_FRONT:  nz = ez + 6'd1;
      STEP_BOTTOM: ny = ey - 6'd1;
      STEP_TOP:    ny = ey + 6'd1;
      STEP_LEFT:   nx = ex - 6'd1;
      STEP_RIGHT:  nx = ex + 6'd1;
      default:     nx = ex;
    endcase
  end

  assign nb_in   = (nx < GRID_C) && (ny < GRID_C) && (nz < GRID_C);
  assign rd_addr = AW'(nz) * PLANE_STEP + AW'(ny) * ROW_STEP + AW'(nx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      occ_mem_r[wr_addr] <= in_data.solid;
    end
    rd_data_r <= occ_mem_r[rd_addr];
  end

  // fold the probe that returned this cycle into the face mask
  always_comb begin
    center_nxt  = center_r;
    exposed_nxt = exposed_r;
    if (cap_en_r) begin
      if (cap_step_r == STEP_CENTER) begin
        center_nxt = rd_data_r;
      end else begin
        exposed_nxt[3'(cap_step_r - 3'd1)] = !(cap_in_r && rd_data_r);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_push    = 1'b0;
    q_data    = '{is_start: 1'b0, cell_x: x_r, cell_y: y_r, cell_z: z_r,
                  exposed: exposed_r};
    case (state_r)
      F_IDLE: begin
        step_nxt = STEP_CENTER;
        if (accept && (in_data.func == FUNC_START)) begin
          q_push          = 1'b1;
          q_data.is_start = 1'b1;
        end else if (accept && (in_data.func == FUNC_MESH) && in_inside) begin
          state_nxt = F_READ;
        end
      end
      F_READ: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_RIGHT) begin
          state_nxt = F_FIN;
        end
      end
      F_FIN: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!center_r || (exposed_r == '0)) begin
          state_nxt = F_IDLE;
        end else if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      cap_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cap_en_r <= (state_r == F_READ);
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    cap_step_r <= step_r;
    cap_in_r   <= nb_in;
    center_r   <= center_nxt;
    exposed_r  <= exposed_nxt;
    if (accept) begin
      x_r <= in_data.cell_x;
      y_r <= in_data.cell_y;
      z_r <= in_data.cell_z;
    end
  end

endmodule

/* design/vfcm_queue.sv */
// short command queue between the front end and the triangle emitter
// depends on vfcm_pkg and the mesher macro header
`include "voxel_face_culling_mesher_macros.svh"
module vfcm_queue
  import vfcm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);

  cmd_t          slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `VFCM_ASSERT_NOW(a_q_no_overflow, push, !full || pop, "queue push while full")
  `VFCM_ASSERT_NOW(a_q_no_underflow, pop, !empty, "queue pop while empty")
  `VFCM_ASSERT_NOW(a_q_count_bound, 1'b1, count_r <= CNT_FULL, "queue count past depth")

endmodule

/* design/vfcm_back.sv */
// back end: turns face masks into triangles, keeps the running triangle count
// depends on vfcm_pkg and the mesher macro header
`include "voxel_face_culling_mesher_macros.svh"
module vfcm_back
  import vfcm_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  output logic      q_pop,
  input  cmd_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int LAT = GRID_SIZE + 1;
  localparam logic [VERT_W-1:0] STEP_Y = VERT_W'(LAT);
  localparam logic [VERT_W-1:0] STEP_Z = VERT_W'(LAT * LAT);

  logic                 busy_r;
  logic [NUM_FACES-1:0] exposed_r;
  logic                 half_r;
  logic [VERT_W-1:0]    base_r;
  logic [TRI_W-1:0]     cnt_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [FACE_W-1:0]    face_sel;
  logic [NUM_FACES-1:0] face_oh, rest;
  logic                 emit, last;
  tri_corners_t         corners;
  logic [VERT_W-1:0]    base_nxt;

  function automatic logic [VERT_W-1:0] corner_off(input logic [2:0] code);
    return (code[0] ? VERT_W'(1) : '0) + (code[1] ? STEP_Y : '0) + (code[2] ? STEP_Z : '0);
  endfunction

  assign q_pop    = !busy_r && !q_empty;
  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign base_nxt = STEP_Z * VERT_W'(q_data.cell_z) + STEP_Y * VERT_W'(q_data.cell_y)
                  + VERT_W'(q_data.cell_x);

  // lowest exposed face goes first
  always_comb begin
    face_sel = FACE_BACK;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (exposed_r[i]) begin
        face_sel = 3'(i);
      end
    end
  end

  assign face_oh = NUM_FACES'(1) << face_sel;
  assign rest    = exposed_r & ~face_oh;
  assign last    = half_r && (rest == '0);
  assign corners = tri_corners(face_sel, half_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_data.is_start) begin
          cnt_r <= '0;
        end else begin
          busy_r <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_r + TRI_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      exposed_r <= q_data.exposed;
      half_r    <= 1'b0;
      base_r    <= base_nxt;
    end
    if (emit) begin
      out_data_r <= '{vert_a: base_r + corner_off(corners.a),
                      vert_b: base_r + corner_off(corners.b),
                      vert_c: base_r + corner_off(corners.c),
                      face: face_sel, tri_number: cnt_r, last: last};
      half_r <= !half_r;
      if (half_r) begin
        exposed_r <= rest;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VFCM_ASSERT_NOW(a_busy_has_faces, busy_r, exposed_r != '0, "emitter busy with empty mask")
  `VFCM_ASSERT_NEXT(a_count_steps, emit, cnt_r == $past(cnt_r) + TRI_W'(1),
                    "triangle count did not step")
  `VFCM_ASSERT_NOW(a_face_legal, out_valid_r, out_data_r.face <= FACE_RIGHT,
                   "triangle face code out of range")

endmodule

/* design/voxel_face_culling_mesher.sv */
// top level of the voxel face-culling mesher
// depends on vfcm_pkg, vfcm_front, vfcm_queue, vfcm_back
//
// keeps a GRID_SIZE^3 occupancy grid and turns a solid cell's exposed faces into
// triangles over the (GRID_SIZE+1)^3 corner lattice. a write item is done as it is
// accepted. a mesh item goes through the front end in order: the accept, seven
// occupancy reads (the cell and its six neighbors), a fold of the last read and the
// queueing of the command, which waits while the queue is full. the emitter picks a
// command off the queue only when idle, then sends one triangle per cycle while the
// output is not stalled, up to twelve, and takes no new command until the last one
// is out. a start item clears the triangle counter in order with the meshes ahead
// of it. the occupancy memory is not cleared at reset: every cell must be written
// before it is meshed; the block itself does not enforce it. a two-entry command
// queue lets the front probe the next cell while the emitter drains the previous one
module voxel_face_culling_mesher
  import vfcm_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front to queue
  logic q_push, q_full;
  cmd_t q_push_data;

  // queue to back
  logic q_pop, q_empty;
  cmd_t q_pop_data;

  // probes occupancy, classifies the item
  vfcm_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_push_data),
    .q_full   (q_full)
  );

  // decouples probing from triangle output
  vfcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // emits two triangles per exposed face, in face order
  vfcm_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* verif/voxel_face_culling_mesher_test.sv */
`timescale 1ns / 100ps
// self-checking testbench of the voxel face-culling mesher, directed table then random items
// depends on vfcm_pkg and voxel_face_culling_mesher
module voxel_face_culling_mesher_test;
  import vfcm_pkg::*;

  localparam int GRID  = GRID_SIZE_DEF;
  localparam int LAT   = GRID + 1;
  localparam int CELLS = GRID * GRID * GRID;
  // func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // long enough for the front end to finish probing an item that emits nothing
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 60;
  localparam out_item_t NO_TRI = '0;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  voxel_face_culling_mesher #(.GRID_SIZE(GRID)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // mesher state as seen by the checker
  bit               occ_grid [CELLS];
  logic [TRI_W-1:0] exp_tri_num;
  out_item_t        face_batch [12];
  int               batch_n;
  out_item_t        pending_tris [$];

  // cells the stimulus has written, so no mesh ever probes an unwritten cell
  bit cell_known [CELLS];

  // typed expectation that rides along with a directed item
  bit        row_typed;
  int        row_n;
  out_item_t row_tris [2];

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int n_items;
  int n_meshes;
  int n_tris_checked;

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        n_exp;
    out_item_t t0;
    out_item_t t1;
  } plan_row_t;

  plan_row_t plan [24];

  function automatic int cell_index(int x, int y, int z);
    return (z * GRID + y) * GRID + x;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 && x < GRID && y < GRID && z < GRID;
  endfunction

  // anything outside the grid reads as empty, so boundary faces are exposed
  function automatic bit is_solid(int x, int y, int z);
    if (!in_grid(x, y, z)) return 1'b0;
    return occ_grid[cell_index(x, y, z)];
  endfunction

  function automatic logic [VERT_W-1:0] lattice_index(int x, int y, int z);
    int v;
    v = z * LAT * LAT + y * LAT + x;
    return v[VERT_W-1:0];
  endfunction

  function automatic void add_tri(logic [FACE_W-1:0] f, logic [VERT_W-1:0] a,
                                  logic [VERT_W-1:0] b, logic [VERT_W-1:0] c);
    face_batch[batch_n] = '{vert_a: a, vert_b: b, vert_c: c, face: f,
                            tri_number: exp_tri_num, last: 1'b0};
    batch_n++;
    exp_tri_num++;
  endfunction

  // updates the grid and counter for one item, triangles land in face_batch
  function automatic void predict_item(in_item_t it);
    int x;
    int y;
    int z;
    x = it.cell_x;
    y = it.cell_y;
    z = it.cell_z;
    batch_n = 0;
    case (it.func)
      FUNC_WRITE: begin
        if (in_grid(x, y, z)) occ_grid[cell_index(x, y, z)] = it.solid;
      end
      FUNC_START: begin
        exp_tri_num = '0;
      end
      FUNC_MESH: begin
        if (in_grid(x, y, z) && is_solid(x, y, z)) begin
          if (!is_solid(x, y, z - 1)) begin
            add_tri(FACE_BACK, lattice_index(x + 1, y + 1, z), lattice_index(x + 1, y, z),
                    lattice_index(x, y, z));
            add_tri(FACE_BACK, lattice_index(x, y, z), lattice_index(x, y + 1, z),
                    lattice_index(x + 1, y + 1, z));
          end
          if (!is_solid(x, y, z + 1)) begin
            add_tri(FACE_FRONT, lattice_index(x, y, z + 1), lattice_index(x + 1, y, z + 1),
                    lattice_index(x + 1, y + 1, z + 1));
            add_tri(FACE_FRONT, lattice_index(x + 1, y + 1, z + 1),
                    lattice_index(x, y + 1, z + 1), lattice_index(x, y, z + 1));
          end
          if (!is_solid(x, y - 1, z)) begin
            add_tri(FACE_BOTTOM, lattice_index(x, y, z), lattice_index(x + 1, y, z),
                    lattice_index(x + 1, y, z + 1));
            add_tri(FACE_BOTTOM, lattice_index(x + 1, y, z + 1), lattice_index(x, y, z + 1),
                    lattice_index(x, y, z));
          end
          if (!is_solid(x, y + 1, z)) begin
            add_tri(FACE_TOP, lattice_index(x + 1, y + 1, z + 1),
                    lattice_index(x + 1, y + 1, z), lattice_index(x, y + 1, z));
            add_tri(FACE_TOP, lattice_index(x, y + 1, z), lattice_index(x, y + 1, z + 1),
                    lattice_index(x + 1, y + 1, z + 1));
          end
          if (!is_solid(x - 1, y, z)) begin
            add_tri(FACE_LEFT, lattice_index(x, y + 1, z + 1), lattice_index(x, y + 1, z),
                    lattice_index(x, y, z));
            add_tri(FACE_LEFT, lattice_index(x, y, z + 1), lattice_index(x, y + 1, z + 1),
                    lattice_index(x, y, z));
          end
          // right face sits on the x+1 plane
          if (!is_solid(x + 1, y, z)) begin
            add_tri(FACE_RIGHT, lattice_index(x + 1, y + 1, z + 1),
                    lattice_index(x + 1, y + 1, z), lattice_index(x + 1, y, z));
            add_tri(FACE_RIGHT, lattice_index(x + 1, y, z + 1),
                    lattice_index(x + 1, y + 1, z + 1), lattice_index(x + 1, y, z));
          end
          if (batch_n > 0) face_batch[batch_n - 1].last = 1'b1;
        end
      end
      default: begin
        // unused code, nothing changes
      end
    endcase
  endfunction

  function automatic string tri_text(out_item_t t);
    return $sformatf("a=%0d b=%0d c=%0d face=%0d tri=%0d last=%0d",
                     t.vert_a, t.vert_b, t.vert_c, t.face, t.tri_number, t.last);
  endfunction

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic in_item_t make_item(logic [1:0] f, int x, int y, int z, bit s);
    in_item_t it;
    it.func   = f;
    it.cell_x = x[COORD_W-1:0];
    it.cell_y = y[COORD_W-1:0];
    it.cell_z = z[COORD_W-1:0];
    it.solid  = s;
    return it;
  endfunction

  function automatic out_item_t mk_tri(int a, int b, int c, logic [FACE_W-1:0] f, int n,
                                       bit l);
    return '{vert_a: a[VERT_W-1:0], vert_b: b[VERT_W-1:0], vert_c: c[VERT_W-1:0],
             face: f, tri_number: n[TRI_W-1:0], last: l};
  endfunction

  // true when the cell and all its in-grid neighbors hold written bits
  function automatic bit ready_to_mesh(int x, int y, int z);
    if (!cell_known[cell_index(x, y, z)]) return 1'b0;
    if (in_grid(x - 1, y, z) && !cell_known[cell_index(x - 1, y, z)]) return 1'b0;
    if (in_grid(x + 1, y, z) && !cell_known[cell_index(x + 1, y, z)]) return 1'b0;
    if (in_grid(x, y - 1, z) && !cell_known[cell_index(x, y - 1, z)]) return 1'b0;
    if (in_grid(x, y + 1, z) && !cell_known[cell_index(x, y + 1, z)]) return 1'b0;
    if (in_grid(x, y, z - 1) && !cell_known[cell_index(x, y, z - 1)]) return 1'b0;
    if (in_grid(x, y, z + 1) && !cell_known[cell_index(x, y, z + 1)]) return 1'b0;
    return 1'b1;
  endfunction

  // mostly inside a small cluster so neighbors interact, sometimes on the grid edge
  function automatic int pick_coord(int lo);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return GRID - 1;
    if (r == 2) return $urandom_range(0, GRID - 1);
    return lo + $urandom_range(0, 3);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side, stalls per cycle at the current rate
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // checker and predictor share one edge: results first, then the accepted item
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      exp_tri_num = '0;
    end else begin
      if (out_valid && out_ready) begin
        n_tris_checked++;
        if (pending_tris.size() == 0) begin
          flag_error($sformatf("unexpected triangle: %s", tri_text(out_data)));
        end else begin
          want = pending_tris.pop_front();
          if (want.vert_a !== out_data.vert_a || want.vert_b !== out_data.vert_b ||
              want.vert_c !== out_data.vert_c || want.face !== out_data.face ||
              want.tri_number !== out_data.tri_number || want.last !== out_data.last)
            flag_error($sformatf("triangle mismatch: expected %s, got %s",
                                 tri_text(want), tri_text(out_data)));
        end
      end
      if (in_valid && in_ready) begin
        predict_item(in_data);
        if (row_typed) begin
          for (int i = 0; i < row_n; i++) pending_tris.push_back(row_tris[i]);
        end else begin
          for (int i = 0; i < batch_n; i++) pending_tris.push_back(face_batch[i]);
        end
      end
    end
  end

  // drives one item, entered and left at a falling edge with valid still high
  task automatic push_item(input in_item_t it, input bit typed, input int n_exp,
                           input out_item_t t0, input out_item_t t1);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_data     = it;
    row_typed   = typed;
    row_n       = n_exp;
    row_tris[0] = t0;
    row_tris[1] = t1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (it.func == FUNC_WRITE && in_grid(it.cell_x, it.cell_y, it.cell_z))
      cell_known[cell_index(it.cell_x, it.cell_y, it.cell_z)] = 1'b1;
    if (it.func != FUNC_UNUSED) n_items++;
    if (it.func == FUNC_MESH) n_meshes++;
  endtask

  task automatic send(input in_item_t it);
    push_item(it, 1'b0, 0, NO_TRI, NO_TRI);
  endtask

  // sender pauses until every triangle is back and the front end has gone quiet
  task automatic hold_off();
    in_valid = 1'b0;
    while (pending_tris.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes a cell unless it is known and the coin says keep it
  task automatic touch_cell(input int x, input int y, input int z, input int solid_pct);
    if (!in_grid(x, y, z)) return;
    if (!cell_known[cell_index(x, y, z)] || $urandom_range(0, 3) == 0)
      send(make_item(FUNC_WRITE, x, y, z, $urandom_range(0, 99) < solid_pct));
  endtask

  // well-formed sequence: settle the neighborhood, then mesh its center
  task automatic mesh_sequence(input int lo);
    int x;
    int y;
    int z;
    x = pick_coord(lo);
    y = pick_coord(lo);
    z = pick_coord(lo);
    touch_cell(x, y, z, 85);
    touch_cell(x, y, z - 1, 55);
    touch_cell(x, y, z + 1, 55);
    touch_cell(x, y - 1, z, 55);
    touch_cell(x, y + 1, z, 55);
    touch_cell(x - 1, y, z, 55);
    touch_cell(x + 1, y, z, 55);
    send(make_item(FUNC_MESH, x, y, z, $urandom_range(0, 1)));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int first;
    int lo;
    int pick;
    int x;
    int y;
    int z;
    hold_off();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    lo    = $urandom_range(0, GRID - 4);
    first = n_items;
    while (n_items - first < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, GRID - 1);
      y = $urandom_range(0, GRID - 1);
      z = $urandom_range(0, GRID - 1);
      if (pick < 70) begin
        mesh_sequence(lo);
      end else if (pick < 80) begin
        send(make_item(FUNC_WRITE, x, y, z, $urandom_range(0, 1)));
      end else if (pick < 86) begin
        send(make_item(FUNC_START, x, y, z, $urandom_range(0, 1)));
      end else if (pick < 92) begin
        send(make_item(FUNC_UNUSED, x, y, z, $urandom_range(0, 1)));
      end else if (pick < 95) begin
        hold_off();
      end else begin
        // mesh again whatever is there now, if it is safe to probe
        x = pick_coord(lo);
        y = pick_coord(lo);
        z = pick_coord(lo);
        if (ready_to_mesh(x, y, z))
          send(make_item(FUNC_MESH, x, y, z, $urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    row_typed      = 1'b0;
    row_n          = 0;
    row_tris[0]    = NO_TRI;
    row_tris[1]    = NO_TRI;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_count      = 0;
    n_items        = 0;
    n_meshes       = 0;
    n_tris_checked = 0;

    // corner cell with every face exposed, counter starts from reset
    plan[0]  = '{make_item(FUNC_WRITE, 0, 0, 0, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[1]  = '{make_item(FUNC_WRITE, 1, 0, 0, 0), 1'b1, 0, NO_TRI, NO_TRI};
    plan[2]  = '{make_item(FUNC_WRITE, 0, 1, 0, 0), 1'b1, 0, NO_TRI, NO_TRI};
    plan[3]  = '{make_item(FUNC_WRITE, 0, 0, 1, 0), 1'b1, 0, NO_TRI, NO_TRI};
    plan[4]  = '{make_item(FUNC_MESH, 0, 0, 0, 0), 1'b0, 0, NO_TRI, NO_TRI};
    // unused code with every field at its top value
    plan[5]  = '{make_item(FUNC_UNUSED, 15, 15, 15, 1), 1'b1, 0, NO_TRI, NO_TRI};
    // buried cell on the x=0 wall: only the left face shows
    plan[6]  = '{make_item(FUNC_WRITE, 0, 5, 5, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[7]  = '{make_item(FUNC_WRITE, 1, 5, 5, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[8]  = '{make_item(FUNC_WRITE, 0, 4, 5, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[9]  = '{make_item(FUNC_WRITE, 0, 6, 5, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[10] = '{make_item(FUNC_WRITE, 0, 5, 4, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[11] = '{make_item(FUNC_WRITE, 0, 5, 6, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[12] = '{make_item(FUNC_START, 15, 15, 15, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[13] = '{make_item(FUNC_MESH, 0, 5, 5, 0), 1'b1, 2,
                 mk_tri(1836, 1547, 1530, FACE_LEFT, 0, 1'b0),
                 mk_tri(1819, 1836, 1530, FACE_LEFT, 1, 1'b1)};
    // buried cell on the far x wall: only the right face, on the x+1 plane
    plan[14] = '{make_item(FUNC_WRITE, 15, 9, 9, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[15] = '{make_item(FUNC_WRITE, 14, 9, 9, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[16] = '{make_item(FUNC_WRITE, 15, 8, 9, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[17] = '{make_item(FUNC_WRITE, 15, 10, 9, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[18] = '{make_item(FUNC_WRITE, 15, 9, 8, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[19] = '{make_item(FUNC_WRITE, 15, 9, 10, 1), 1'b1, 0, NO_TRI, NO_TRI};
    plan[20] = '{make_item(FUNC_MESH, 15, 9, 9, 1), 1'b1, 2,
                 mk_tri(3076, 2787, 2770, FACE_RIGHT, 2, 1'b0),
                 mk_tri(3059, 3076, 2770, FACE_RIGHT, 3, 1'b1)};
    // clear a cell and mesh it: empty, so nothing comes out
    plan[21] = '{make_item(FUNC_WRITE, 0, 5, 5, 0), 1'b1, 0, NO_TRI, NO_TRI};
    plan[22] = '{make_item(FUNC_MESH, 0, 5, 5, 1), 1'b1, 0, NO_TRI, NO_TRI};
    // counter carries on from the earlier meshes
    plan[23] = '{make_item(FUNC_MESH, 0, 0, 0, 1), 1'b0, 0, NO_TRI, NO_TRI};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      push_item(plan[i].item, plan[i].typed, plan[i].n_exp, plan[i].t0, plan[i].t1);

    // random phases: no idling, sender idle, receiver stall, both
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(17, 17);

    hold_off();
    $display("covered %0d items, %0d of them meshes, %0d triangles checked",
             n_items, n_meshes, n_tris_checked);
    $display("grid edges, empty and buried cells, unused codes, idle and stall mixes");
    if (err_count == 0 && pending_tris.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d failures", err_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d triangles outstanding", pending_tris.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
